// ===== src/fpl_pkg.sv =====
// ----------------------------------------------------------------------------
// fpl_pkg
// Shared widths, constants and the arctangent table of the face pose pipeline.
// ----------------------------------------------------------------------------
package fpl_pkg;

    localparam int BOX_BITS     = 12;
    localparam int LM_BITS      = 17;
    localparam int LM_FRAC      = 4;
    localparam int ANG_FRAC     = 7;

    localparam int DIFF_W       = LM_BITS + 1;
    localparam int NUM_W        = LM_BITS + 4;
    localparam int DEN_W        = BOX_BITS + LM_FRAC;
    localparam int QUO_W        = 14;
    localparam int ROLL_W       = 16;

    localparam int CORDIC_STEPS = 24;
    localparam int PRE_SHIFT    = 24;
    localparam int ZFRAC        = 20;
    localparam int XY_W         = DIFF_W + PRE_SHIFT + 3;
    localparam int Z_W          = 30;
    localparam int ROUND_SH     = ZFRAC - ANG_FRAC;

    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int DIV_LAT      = QUO_W + 3;
    localparam int ALIGN_DLY    = CORDIC_LAT - DIV_LAT;
    localparam int PIPE_LAT     = CORDIC_LAT + 2;

    localparam int YAW_K        = 45 << ANG_FRAC;
    localparam int YAW_LIM      = 60 << ANG_FRAC;
    localparam int PITCH_K      = 30 << ANG_FRAC;
    localparam int PITCH_LIM    = 45 << ANG_FRAC;

    localparam logic signed [ROLL_W-1:0] ROLL_180 = ROLL_W'(180 << ANG_FRAC);
    localparam logic signed [ROLL_W-1:0] ROLL_90  = ROLL_W'(90 << ANG_FRAC);
    localparam logic signed [Z_W-1:0]    Z_90     = Z_W'(90 << ZFRAC);

    // atan(2^-i) in degrees, 2^-20 degree units
    localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        Z_W'(47185920), Z_W'(27855475), Z_W'(14718068), Z_W'(7471121),
        Z_W'(3750058),  Z_W'(1876857),  Z_W'(938658),   Z_W'(469357),
        Z_W'(234682),   Z_W'(117342),   Z_W'(58671),    Z_W'(29335),
        Z_W'(14668),    Z_W'(7334),     Z_W'(3667),     Z_W'(1833),
        Z_W'(917),      Z_W'(458),      Z_W'(229),      Z_W'(115),
        Z_W'(57),       Z_W'(29),       Z_W'(14),       Z_W'(7)
    };

endpackage

// ===== src/fpl_cordic.sv =====
// ----------------------------------------------------------------------------
// fpl_cordic
// Pipelined vectoring CORDIC: atan2 of the eye difference, one step per stage.
// ----------------------------------------------------------------------------
module fpl_cordic
    import fpl_pkg::*;
(
    input  logic                     aclk,
    input  logic                     ce,
    input  logic signed [DIFF_W-1:0] dx,
    input  logic signed [DIFF_W-1:0] dy,
    output logic signed [ROLL_W-1:0] roll
);

    logic signed [XY_W-1:0]   x_reg [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]   y_reg [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]    z_reg [CORDIC_STEPS+1];
    logic                     spec_reg [CORDIC_STEPS+1];
    logic signed [ROLL_W-1:0] sval_reg [CORDIC_STEPS+1];

    logic signed [XY_W-1:0]   xs, ys, x_next, y_next;
    logic signed [Z_W-1:0]    z_next;
    logic                     spec_next;
    logic signed [ROLL_W-1:0] sval_next;
    logic [Z_W-1:0]           z_mag, z_rnd;
    logic signed [ROLL_W-1:0] roll_next, roll_reg;

    // axis cases and pre-rotation into the right half-plane
    always_comb begin
        xs        = XY_W'(dx) <<< PRE_SHIFT;
        ys        = XY_W'(dy) <<< PRE_SHIFT;
        spec_next = (dy == 0) || (dx == 0);
        if (dy == 0) begin
            sval_next = (dx < 0) ? ROLL_180 : '0;
        end else begin
            sval_next = (dy > 0) ? ROLL_90 : -ROLL_90;
        end
        if (dx < 0) begin
            if (dy > 0) begin
                x_next = ys;
                y_next = -xs;
                z_next = Z_90;
            end else begin
                x_next = -ys;
                y_next = xs;
                z_next = -Z_90;
            end
        end else begin
            x_next = xs;
            y_next = ys;
            z_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg[0]    <= x_next;
            y_reg[0]    <= y_next;
            z_reg[0]    <= z_next;
            spec_reg[0] <= spec_next;
            sval_reg[0] <= sval_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                spec_reg[i+1] <= spec_reg[i];
                sval_reg[i+1] <= sval_reg[i];
            end
        end
    end

    // round to output resolution, ties away from zero
    always_comb begin
        z_mag = (z_reg[CORDIC_STEPS] < 0) ? Z_W'(-z_reg[CORDIC_STEPS])
                                          : Z_W'(z_reg[CORDIC_STEPS]);
        z_rnd = (z_mag + (Z_W'(1) << (ROUND_SH - 1))) >> ROUND_SH;
        if (spec_reg[CORDIC_STEPS]) begin
            roll_next = sval_reg[CORDIC_STEPS];
        end else if (z_reg[CORDIC_STEPS] < 0) begin
            roll_next = -$signed(z_rnd[ROLL_W-1:0]);
        end else begin
            roll_next = $signed(z_rnd[ROLL_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            roll_reg <= roll_next;
        end
    end

    assign roll = roll_reg;

endmodule

// ===== src/fpl_div.sv =====
// ----------------------------------------------------------------------------
// fpl_div
// Scaled, rounded and clamped signed quotient: one restoring step per stage.
// ----------------------------------------------------------------------------
module fpl_div
    import fpl_pkg::*;
#(
    parameter int K     = 5760,
    parameter int LIMIT = 7680
)
(
    input  logic                     aclk,
    input  logic                     ce,
    input  logic signed [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]         den,
    output logic signed [QUO_W-1:0]  quo
);

    localparam int KW     = $clog2(K + 1);
    localparam int PROD_W = NUM_W - 1 + KW;
    localparam int REM_W  = PROD_W + 2;
    localparam int DD_W   = DEN_W + 1;

    logic [NUM_W-1:0]  mag;
    logic [PROD_W-1:0] prod_reg;
    logic [DEN_W-1:0]  den_p_reg;
    logic              sgn_p_reg;

    logic [REM_W-1:0]  n_val;
    logic [DD_W-1:0]   dd_val;

    logic [REM_W-1:0]  rem_reg [QUO_W+1];
    logic [DD_W-1:0]   dd_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg   [QUO_W+1];
    logic              sgn_reg [QUO_W+1];
    logic              ovf_reg [QUO_W+1];

    logic [QUO_W-1:0]  q_clamp;
    logic signed [QUO_W-1:0] quo_reg;

    assign mag = (num < 0) ? NUM_W'(-num) : NUM_W'(num);

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg  <= PROD_W'(mag) * PROD_W'(K);
            den_p_reg <= den;
            sgn_p_reg <= num[NUM_W-1];
        end
    end

    // (2*|n|*K + d) / (2*d) gives round-half-away
    assign n_val  = (REM_W'(prod_reg) << 1) + REM_W'(den_p_reg);
    assign dd_val = {den_p_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg[0] <= n_val;
            dd_reg[0]  <= dd_val;
            q_reg[0]   <= '0;
            sgn_reg[0] <= sgn_p_reg;
            ovf_reg[0] <= n_val >= (REM_W'(dd_val) << QUO_W);
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             ge;
        assign trial = REM_W'(dd_reg[j]) << (QUO_W - 1 - j);
        assign ge    = rem_reg[j] >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[j+1] <= ge ? rem_reg[j] - trial : rem_reg[j];
                q_reg[j+1]   <= {q_reg[j][QUO_W-2:0], ge};
                dd_reg[j+1]  <= dd_reg[j];
                sgn_reg[j+1] <= sgn_reg[j];
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign q_clamp = (ovf_reg[QUO_W] || q_reg[QUO_W] > QUO_W'(LIMIT))
                     ? QUO_W'(LIMIT) : q_reg[QUO_W];

    always_ff @(posedge aclk) begin
        if (ce) begin
            quo_reg <= sgn_reg[QUO_W] ? -$signed(q_clamp) : $signed(q_clamp);
        end
    end

    assign quo = quo_reg;

endmodule

// ===== src/face_pose_from_landmarks.sv =====
// ----------------------------------------------------------------------------
// face_pose_from_landmarks
// Head roll, yaw and pitch from a face box and five-point landmarks.
// ----------------------------------------------------------------------------
// Fully pipelined: one face per clock while m_tready does not stall. The
// pipeline depth is set by the 24-stage CORDIC for roll plus its input
// and rounding stages; yaw and pitch use 14-stage restoring dividers that are
// delayed to line up with it. A stall on m_tready freezes the whole pipeline.
// Angles are in 1/128 degree; a zero box width or height gives m_tuser = 0
// and all angles zero.
module face_pose_from_landmarks
    import fpl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // box_left, box_top, box_width, box_height, right_eye_x, right_eye_y,
    // left_eye_x, left_eye_y, nose_x, nose_y, right_mouth_y, left_mouth_y
    input  logic [183:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // roll_angle, yaw_angle, pitch_angle, zero pad
    output logic [47:0]  m_tdata,
    // pose_valid
    output logic [0:0]   m_tuser
);

    logic                     ce;
    logic [BOX_BITS-1:0]      box_left, box_width, box_height;
    logic signed [LM_BITS-1:0] rex, rey, lex, ley, nx, ny, rmy, lmy;
    logic [BOX_BITS+1:0]      lw;
    logic [NUM_W-1:0]         ofs;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [NUM_W-1:0]  yaw_num_reg, pitch_num_reg;
    logic [DEN_W-1:0]         yaw_den_reg, pitch_den_reg;

    logic [PIPE_LAT-1:0]      vld_reg;
    logic                     ok_reg [CORDIC_LAT+1];

    logic signed [ROLL_W-1:0] roll;
    logic signed [QUO_W-1:0]  yaw, pitch;
    logic signed [QUO_W-1:0]  yaw_dly_reg   [ALIGN_DLY];
    logic signed [QUO_W-1:0]  pitch_dly_reg [ALIGN_DLY];

    logic [47:0]              tdata_reg;
    logic                     tuser_reg;

    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce && aresetn;

    assign box_left   = s_tdata[11:0];
    assign box_width  = s_tdata[35:24];
    assign box_height = s_tdata[47:36];
    assign rex = $signed(s_tdata[64:48]);
    assign rey = $signed(s_tdata[81:65]);
    assign lex = $signed(s_tdata[98:82]);
    assign ley = $signed(s_tdata[115:99]);
    assign nx  = $signed(s_tdata[132:116]);
    assign ny  = $signed(s_tdata[149:133]);
    assign rmy = $signed(s_tdata[166:150]);
    assign lmy = $signed(s_tdata[183:167]);

    // 2*left + width, scaled to landmark units
    assign lw  = {1'b0, box_left, 1'b0} + {2'b0, box_width};
    assign ofs = NUM_W'(lw) << LM_FRAC;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx_reg        <= DIFF_W'(lex) - DIFF_W'(rex);
            dy_reg        <= DIFF_W'(ley) - DIFF_W'(rey);
            yaw_num_reg   <= (NUM_W'(nx) <<< 1) - $signed(ofs);
            pitch_num_reg <= (NUM_W'(ny) <<< 2)
                             - (NUM_W'(ley) + NUM_W'(rey) + NUM_W'(lmy) + NUM_W'(rmy));
            yaw_den_reg   <= DEN_W'(box_width) << LM_FRAC;
            pitch_den_reg <= DEN_W'(box_height) << LM_FRAC;
            ok_reg[0]     <= (box_width != '0) && (box_height != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    for (genvar k = 1; k <= CORDIC_LAT; k++) begin : g_ok
        always_ff @(posedge aclk) begin
            if (ce) begin
                ok_reg[k] <= ok_reg[k-1];
            end
        end
    end

    fpl_cordic u_cordic (
        .aclk (aclk),
        .ce   (ce),
        .dx   (dx_reg),
        .dy   (dy_reg),
        .roll (roll)
    );

    fpl_div #(.K(YAW_K), .LIMIT(YAW_LIM)) u_div_yaw (
        .aclk (aclk),
        .ce   (ce),
        .num  (yaw_num_reg),
        .den  (yaw_den_reg),
        .quo  (yaw)
    );

    fpl_div #(.K(PITCH_K), .LIMIT(PITCH_LIM)) u_div_pitch (
        .aclk (aclk),
        .ce   (ce),
        .num  (pitch_num_reg),
        .den  (pitch_den_reg),
        .quo  (pitch)
    );

    // line the divider results up with the CORDIC output
    always_ff @(posedge aclk) begin
        if (ce) begin
            yaw_dly_reg[0]   <= yaw;
            pitch_dly_reg[0] <= pitch;
        end
    end

    for (genvar k = 1; k < ALIGN_DLY; k++) begin : g_align
        always_ff @(posedge aclk) begin
            if (ce) begin
                yaw_dly_reg[k]   <= yaw_dly_reg[k-1];
                pitch_dly_reg[k] <= pitch_dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tuser_reg <= ok_reg[CORDIC_LAT];
            if (ok_reg[CORDIC_LAT]) begin
                tdata_reg <= {4'b0, pitch_dly_reg[ALIGN_DLY-1],
                              yaw_dly_reg[ALIGN_DLY-1], roll};
            end else begin
                tdata_reg <= '0;
            end
        end
    end

    assign m_tvalid   = vld_reg[PIPE_LAT-1];
    assign m_tdata    = tdata_reg;
    assign m_tuser[0] = tuser_reg;

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid pose carries nonzero angles");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[29:16]) <= $signed(14'(YAW_LIM))
                  && $signed(m_tdata[29:16]) >= -$signed(14'(YAW_LIM)))
        else $error("yaw outside clamp");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[43:30]) <= $signed(14'(PITCH_LIM))
                  && $signed(m_tdata[43:30]) >= -$signed(14'(PITCH_LIM)))
        else $error("pitch outside clamp");

    a_roll_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[15:0]) <= ROLL_180
                  && $signed(m_tdata[15:0]) >= -ROLL_180)
        else $error("roll outside half turn");
`endif

endmodule
